[hw/rtl/dlc_pkg.sv]
// Shared types and codes for the password door lock controller.
`timescale 1ns / 1ps
package dlc_pkg;

	// event kinds
	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_BYTE = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// command codes
	localparam logic [7:0] CMD_CHECK   = 8'd0;
	localparam logic [7:0] CMD_OPEN    = 8'd1;
	localparam logic [7:0] CMD_CHANGE  = 8'd2;
	localparam logic [7:0] CMD_FIRST   = 8'd3;
	localparam logic [7:0] CMD_CONFIRM = 8'd4;

	// reply codes
	localparam logic [2:0] RPL_NONE     = 3'd0;
	localparam logic [2:0] RPL_DIFFER   = 3'd1;
	localparam logic [2:0] RPL_MATCH    = 3'd2;
	localparam logic [2:0] RPL_OPENING  = 3'd3;
	localparam logic [2:0] RPL_WRONG    = 3'd4;
	localparam logic [2:0] RPL_CHANGING = 3'd5;

	// motor codes
	localparam logic [1:0] MOTOR_STOP    = 2'd0;
	localparam logic [1:0] MOTOR_FORWARD = 2'd1;
	localparam logic [1:0] MOTOR_REVERSE = 2'd2;

	// register indexes
	localparam logic [1:0] REG_MISTAKE_LIMIT = 2'd0;
	localparam logic [1:0] REG_MOVE_TICKS    = 2'd1;
	localparam logic [1:0] REG_HOLD_TICKS    = 2'd2;
	localparam logic [1:0] REG_LOCKOUT_TICKS = 2'd3;

	localparam logic [7:0] RST_MISTAKE_LIMIT = 8'd3;
	localparam logic [7:0] RST_MOVE_TICKS    = 8'd15;
	localparam logic [7:0] RST_HOLD_TICKS    = 8'd3;
	localparam logic [7:0] RST_LOCKOUT_TICKS = 8'd60;

	typedef enum logic [10:0] {
		PH_ENROLL_CMD    = 11'b000_0000_0001,
		PH_ENROLL_BYTES  = 11'b000_0000_0010,
		PH_CONFIRM_CMD   = 11'b000_0000_0100,
		PH_CONFIRM_BYTES = 11'b000_0000_1000,
		PH_IDLE          = 11'b000_0001_0000,
		PH_CHECK_BYTES   = 11'b000_0010_0000,
		PH_OPTION        = 11'b000_0100_0000,
		PH_OPENING       = 11'b000_1000_0000,
		PH_HOLDING       = 11'b001_0000_0000,
		PH_CLOSING       = 11'b010_0000_0000,
		PH_LOCKOUT       = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] value;
	} in_t;

	typedef struct packed {
		logic [2:0] reply;
		logic [1:0] motor_drive;
		logic       alarm_on;
		logic       busy_res;
	} out_t;

endpackage

[hw/rtl/dlc_code_mem.sv]
// Code memory: first-entry bank and stored-code bank, one write and one read port.
`timescale 1ns / 1ps
module dlc_code_mem #(
	parameter int CODE_LENGTH = 5,
	parameter int AW = $clog2(2 * CODE_LENGTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [2*CODE_LENGTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/dlc_ctrl.sv]
// Lock sequencer: phases, counters, config registers and code memory access.
`timescale 1ns / 1ps
module dlc_ctrl #(
	parameter int CODE_LENGTH = 5,
	parameter int AW = $clog2(2 * CODE_LENGTH),
	parameter int PW = $clog2(CODE_LENGTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  dlc_pkg::in_t  item,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output dlc_pkg::out_t result,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [7:0]    mem_rdata
);

	localparam logic [PW-1:0] LAST_POS = PW'(CODE_LENGTH - 1);
	localparam logic [PW-1:0] CODE_LEN = PW'(CODE_LENGTH);
	localparam logic [AW-1:0] BANK_OFS = AW'(CODE_LENGTH);

	dlc_pkg::phase_t phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic          match_q, match_d;
	logic [7:0]    mistakes_q, mistakes_d;
	logic [7:0]    ticks_q, ticks_d;
	logic          sel_q, sel_d;  // bank that holds the stored code
	logic [7:0]    limit_q, move_q, hold_q, lockout_q;

	logic          is_cmd, is_byte, is_tick;
	logic          byte_eq, last_byte, opt_known;
	logic [7:0]    tick_inc, mistake_inc, tick_limit;
	logic          tick_end;
	logic [2:0]    reply;
	logic          rd_bank;
	logic [PW-1:0] rd_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= dlc_pkg::RST_MISTAKE_LIMIT;
			move_q    <= dlc_pkg::RST_MOVE_TICKS;
			hold_q    <= dlc_pkg::RST_HOLD_TICKS;
			lockout_q <= dlc_pkg::RST_LOCKOUT_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlc_pkg::REG_MISTAKE_LIMIT: limit_q   <= cfg_data;
				dlc_pkg::REG_MOVE_TICKS:    move_q    <= cfg_data;
				dlc_pkg::REG_HOLD_TICKS:    hold_q    <= cfg_data;
				dlc_pkg::REG_LOCKOUT_TICKS: lockout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign is_cmd    = take && (item.mode == dlc_pkg::MODE_CMD);
	assign is_byte   = take && (item.mode == dlc_pkg::MODE_BYTE);
	assign is_tick   = take && (item.mode == dlc_pkg::MODE_TICK);
	// mem_rdata already holds the entry at pos_q of the bank this phase compares against
	assign byte_eq   = (mem_rdata == item.value);
	assign last_byte = (pos_q == LAST_POS);
	assign opt_known = (item.value == dlc_pkg::CMD_OPEN) || (item.value == dlc_pkg::CMD_CHANGE);

	assign tick_inc    = (ticks_q == 8'hFF) ? ticks_q : ticks_q + 8'd1;
	assign mistake_inc = (mistakes_q == 8'hFF) ? mistakes_q : mistakes_q + 8'd1;

	always_comb begin
		unique case (phase_q)
			dlc_pkg::PH_HOLDING: tick_limit = hold_q;
			dlc_pkg::PH_LOCKOUT: tick_limit = lockout_q;
			default:             tick_limit = move_q;
		endcase
	end
	assign tick_end = (tick_inc >= tick_limit);

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		match_d    = match_q;
		mistakes_d = mistakes_q;
		ticks_d    = ticks_q;
		sel_d      = sel_q;
		reply      = dlc_pkg::RPL_NONE;
		mem_we     = 1'b0;

		unique case (phase_q) inside
			dlc_pkg::PH_ENROLL_CMD: begin
				if (is_cmd && item.value == dlc_pkg::CMD_FIRST) begin
					phase_d = dlc_pkg::PH_ENROLL_BYTES;
					pos_d   = '0;
					match_d = 1'b1;
				end
			end
			dlc_pkg::PH_ENROLL_BYTES: begin
				if (is_byte) begin
					mem_we = 1'b1;
					pos_d  = pos_q + PW'(1);
					if (!byte_eq) match_d = 1'b0;
					if (last_byte) phase_d = dlc_pkg::PH_CONFIRM_CMD;
				end
			end
			dlc_pkg::PH_CONFIRM_CMD: begin
				if (is_cmd && item.value == dlc_pkg::CMD_CONFIRM) begin
					phase_d = dlc_pkg::PH_CONFIRM_BYTES;
					pos_d   = '0;
					match_d = 1'b1;
				end
			end
			dlc_pkg::PH_CONFIRM_BYTES: begin
				if (is_byte) begin
					pos_d   = pos_q + PW'(1);
					match_d = match_q && byte_eq;
					if (last_byte) begin
						if (match_q && byte_eq) begin
							// first-entry bank becomes the stored code
							sel_d   = ~sel_q;
							reply   = dlc_pkg::RPL_MATCH;
							phase_d = dlc_pkg::PH_IDLE;
						end else begin
							reply   = dlc_pkg::RPL_DIFFER;
							phase_d = dlc_pkg::PH_ENROLL_CMD;
							pos_d   = '0;
							match_d = 1'b1;
						end
					end
				end
			end
			dlc_pkg::PH_IDLE: begin
				if (is_cmd && item.value == dlc_pkg::CMD_CHECK) begin
					phase_d = dlc_pkg::PH_CHECK_BYTES;
					pos_d   = '0;
					match_d = 1'b1;
				end
			end
			dlc_pkg::PH_CHECK_BYTES: begin
				if (is_byte) begin
					pos_d   = pos_q + PW'(1);
					match_d = match_q && byte_eq;
					if (last_byte) phase_d = dlc_pkg::PH_OPTION;
				end
			end
			dlc_pkg::PH_OPTION: begin
				if (is_cmd) begin
					if (!opt_known) begin
						phase_d = dlc_pkg::PH_IDLE;
					end else if (!match_q) begin
						reply      = dlc_pkg::RPL_WRONG;
						mistakes_d = mistake_inc;
						if (mistake_inc >= limit_q) begin
							phase_d = dlc_pkg::PH_LOCKOUT;
							ticks_d = '0;
						end else begin
							phase_d = dlc_pkg::PH_IDLE;
						end
					end else if (item.value == dlc_pkg::CMD_OPEN) begin
						reply   = dlc_pkg::RPL_OPENING;
						phase_d = dlc_pkg::PH_OPENING;
						ticks_d = '0;
					end else begin
						reply   = dlc_pkg::RPL_CHANGING;
						phase_d = dlc_pkg::PH_ENROLL_CMD;
						pos_d   = '0;
						match_d = 1'b1;
					end
				end
			end
			dlc_pkg::PH_OPENING, dlc_pkg::PH_HOLDING,
			dlc_pkg::PH_CLOSING, dlc_pkg::PH_LOCKOUT: begin
				if (is_tick) begin
					ticks_d = tick_end ? 8'd0 : tick_inc;
					if (tick_end) begin
						unique case (phase_q)
							dlc_pkg::PH_OPENING: phase_d = dlc_pkg::PH_HOLDING;
							dlc_pkg::PH_HOLDING: phase_d = dlc_pkg::PH_CLOSING;
							dlc_pkg::PH_CLOSING: phase_d = dlc_pkg::PH_IDLE;
							default: begin
								mistakes_d = '0;
								phase_d    = dlc_pkg::PH_IDLE;
							end
						endcase
					end
				end
			end
			default: begin
				if (take) begin
					phase_d = dlc_pkg::PH_ENROLL_CMD;
					pos_d   = '0;
					match_d = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dlc_pkg::PH_ENROLL_CMD;
			pos_q      <= '0;
			match_q    <= 1'b1;
			mistakes_q <= '0;
			ticks_q    <= '0;
			sel_q      <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			match_q    <= match_d;
			mistakes_q <= mistakes_d;
			ticks_q    <= ticks_d;
			sel_q      <= sel_d;
		end
	end

	// prefetch the entry the next byte will be compared against
	assign rd_bank = (phase_d == dlc_pkg::PH_CHECK_BYTES) ? sel_d : ~sel_d;
	assign rd_pos  = (pos_d >= CODE_LEN) ? '0 : pos_d;
	assign mem_raddr = rd_bank ? (AW'(rd_pos) + BANK_OFS) : AW'(rd_pos);

	assign mem_waddr = (~sel_q) ? (AW'(pos_q) + BANK_OFS) : AW'(pos_q);
	assign mem_wdata = item.value;

	always_comb begin
		result.reply       = reply;
		result.motor_drive = (phase_d == dlc_pkg::PH_OPENING) ? dlc_pkg::MOTOR_FORWARD :
		                     (phase_d == dlc_pkg::PH_CLOSING) ? dlc_pkg::MOTOR_REVERSE :
		                                                        dlc_pkg::MOTOR_STOP;
		result.alarm_on    = (phase_d == dlc_pkg::PH_LOCKOUT);
		result.busy_res    = (phase_d == dlc_pkg::PH_OPENING) ||
		                     (phase_d == dlc_pkg::PH_HOLDING) ||
		                     (phase_d == dlc_pkg::PH_CLOSING) ||
		                     (phase_d == dlc_pkg::PH_LOCKOUT);
	end

endmodule

[hw/rtl/password_door_lock_controller_core.sv]
// Password door lock controller: top level with output register.
// Input channel in_valid / in_stall / in_data carries one event beat
// (mode: command, password byte or timer tick; value: command code or byte).
// Every accepted event gives exactly one result beat on out_valid / out_stall /
// out_data: reply code, motor drive, buzzer and busy flags after that event.
// Each result is registered: it appears in the cycle after its event is taken.
// Throughput: one event per cycle unless in_stall is high; the phase logic settles
// within the cycle; the code memory is read one entry ahead of the next byte.
// The output register holds a result while out_stall is high; in_stall is
// raised only while that register is full and stalled, so a new event is
// taken in the same cycle the previous result leaves.
// Configuration: cfg_we writes register cfg_index with cfg_data;
// write only while no events are in flight.
// Reset (arst_n low) puts the lock in enrollment, clears counters and loads
// default timing; the code memory is not cleared and needs no clearing pass,
// since enrollment writes every entry before any compare reads it.
`timescale 1ns / 1ps
module password_door_lock_controller_core #(
	parameter int CODE_LENGTH = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dlc_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output dlc_pkg::out_t out_data,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

	localparam int AW = $clog2(2 * CODE_LENGTH);
	localparam int PW = $clog2(CODE_LENGTH + 1);

	logic          take;
	dlc_pkg::out_t result;
	logic          out_valid_q;
	dlc_pkg::out_t out_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;

	assign in_stall = out_valid_q && out_stall;
	assign take     = in_valid && !in_stall;

	dlc_ctrl #(
		.CODE_LENGTH(CODE_LENGTH),
		.AW(AW),
		.PW(PW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.result   (result),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	dlc_code_mem #(
		.CODE_LENGTH(CODE_LENGTH),
		.AW(AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!in_stall) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// an accepted event always leaves a result beat in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid)
		else $error("accepted event produced no result beat");

	// input stalls only behind a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a pending result");

	// buzzer and motor belong to timed phases and never overlap
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((!out_data.alarm_on || out_data.busy_res) &&
		              (out_data.motor_drive == dlc_pkg::MOTOR_STOP ||
		               (out_data.busy_res && !out_data.alarm_on))))
		else $error("inconsistent motor, buzzer and busy flags");

endmodule

[verif/password_door_lock_controller_core_tb.sv]
// Testbench for the door lock core: directed and random events checked against a predictor.
`timescale 1ns / 1ps
module password_door_lock_controller_core_tb;

	localparam int CODE_LEN = 5;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [39:0] CODE_EXTREME = 40'h00_FF_80_7F_01;
	localparam logic [39:0] CODE_WRONG   = 40'h00_FF_80_7F_00;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          in_valid  = 1'b0;
	logic          in_stall;
	dlc_pkg::in_t  in_data   = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	dlc_pkg::out_t out_data;
	logic          cfg_we    = 1'b0;
	logic [1:0]    cfg_index = '0;
	logic [7:0]    cfg_data  = '0;

	password_door_lock_controller_core #(.CODE_LENGTH(CODE_LEN)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// lock state as predicted
	dlc_pkg::phase_t lk_phase;
	logic [7:0] lk_stored [CODE_LEN];
	logic [7:0] lk_first  [CODE_LEN];
	int         lk_pos;
	logic       lk_match;
	logic [7:0] lk_mistakes;
	logic [7:0] lk_ticks;
	logic [7:0] reg_limit, reg_move, reg_hold, reg_lockout;

	dlc_pkg::out_t expected_beats [$];
	dlc_pkg::out_t exp_beat;

	int n_err = 0;
	int n_events = 0, n_stored = 0, n_differ = 0, n_open = 0;
	int n_wrong = 0, n_change = 0, n_lockout = 0;
	int idle_pct = 10;
	int stall_pct = 10;

	function automatic void start_entry(dlc_pkg::phase_t nxt);
		lk_phase = nxt;
		lk_pos   = 0;
		lk_match = 1'b1;
	endfunction

	function automatic void lock_reset();
		reg_limit   = dlc_pkg::RST_MISTAKE_LIMIT;
		reg_move    = dlc_pkg::RST_MOVE_TICKS;
		reg_hold    = dlc_pkg::RST_HOLD_TICKS;
		reg_lockout = dlc_pkg::RST_LOCKOUT_TICKS;
		foreach (lk_stored[i]) begin
			lk_stored[i] = '0;
			lk_first[i]  = '0;
		end
		start_entry(dlc_pkg::PH_ENROLL_CMD);
		lk_mistakes = '0;
		lk_ticks    = '0;
	endfunction

	// compares one byte against the stored code or the first entry; true once the entry is full
	function automatic bit take_byte(bit vs_stored, logic [7:0] b, bit keep);
		logic [7:0] want;
		if (lk_pos < CODE_LEN) begin
			want = vs_stored ? lk_stored[lk_pos] : lk_first[lk_pos];
			if (want != b)
				lk_match = 1'b0;
			if (keep)
				lk_first[lk_pos] = b;
			lk_pos++;
		end
		return lk_pos >= CODE_LEN;
	endfunction

	function automatic bit tick_done(logic [7:0] lim);
		if (lk_ticks < 8'd255)
			lk_ticks++;
		if (lk_ticks >= lim) begin
			lk_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit lock_timed();
		return lk_phase == dlc_pkg::PH_OPENING || lk_phase == dlc_pkg::PH_HOLDING ||
			lk_phase == dlc_pkg::PH_CLOSING || lk_phase == dlc_pkg::PH_LOCKOUT;
	endfunction

	function automatic dlc_pkg::out_t predict_event(dlc_pkg::in_t ev);
		dlc_pkg::out_t r;
		bit            is_cmd, is_byte, is_tick;
		r       = '0;
		r.reply = dlc_pkg::RPL_NONE;
		is_cmd  = ev.mode == dlc_pkg::MODE_CMD;
		is_byte = ev.mode == dlc_pkg::MODE_BYTE;
		is_tick = ev.mode == dlc_pkg::MODE_TICK;
		n_events++;
		unique case (lk_phase)
			dlc_pkg::PH_ENROLL_CMD: begin
				if (is_cmd && ev.value == dlc_pkg::CMD_FIRST)
					start_entry(dlc_pkg::PH_ENROLL_BYTES);
			end
			dlc_pkg::PH_ENROLL_BYTES: begin
				if (is_byte && take_byte(1'b0, ev.value, 1'b1))
					lk_phase = dlc_pkg::PH_CONFIRM_CMD;
			end
			dlc_pkg::PH_CONFIRM_CMD: begin
				if (is_cmd && ev.value == dlc_pkg::CMD_CONFIRM)
					start_entry(dlc_pkg::PH_CONFIRM_BYTES);
			end
			dlc_pkg::PH_CONFIRM_BYTES: begin
				if (is_byte && take_byte(1'b0, ev.value, 1'b0)) begin
					if (lk_match) begin
						foreach (lk_stored[i])
							lk_stored[i] = lk_first[i];
						r.reply  = dlc_pkg::RPL_MATCH;
						lk_phase = dlc_pkg::PH_IDLE;
						n_stored++;
					end else begin
						r.reply = dlc_pkg::RPL_DIFFER;
						start_entry(dlc_pkg::PH_ENROLL_CMD);
						n_differ++;
					end
				end
			end
			dlc_pkg::PH_IDLE: begin
				if (is_cmd && ev.value == dlc_pkg::CMD_CHECK)
					start_entry(dlc_pkg::PH_CHECK_BYTES);
			end
			dlc_pkg::PH_CHECK_BYTES: begin
				if (is_byte && take_byte(1'b1, ev.value, 1'b0))
					lk_phase = dlc_pkg::PH_OPTION;
			end
			dlc_pkg::PH_OPTION: begin
				if (is_cmd) begin
					if (ev.value != dlc_pkg::CMD_OPEN && ev.value != dlc_pkg::CMD_CHANGE) begin
						lk_phase = dlc_pkg::PH_IDLE;
					end else if (!lk_match) begin
						r.reply = dlc_pkg::RPL_WRONG;
						n_wrong++;
						if (lk_mistakes < 8'd255)
							lk_mistakes++;
						if (lk_mistakes >= reg_limit) begin
							lk_phase = dlc_pkg::PH_LOCKOUT;
							lk_ticks = '0;
							n_lockout++;
						end else begin
							lk_phase = dlc_pkg::PH_IDLE;
						end
					end else if (ev.value == dlc_pkg::CMD_OPEN) begin
						r.reply  = dlc_pkg::RPL_OPENING;
						lk_phase = dlc_pkg::PH_OPENING;
						lk_ticks = '0;
						n_open++;
					end else begin
						r.reply = dlc_pkg::RPL_CHANGING;
						start_entry(dlc_pkg::PH_ENROLL_CMD);
						n_change++;
					end
				end
			end
			dlc_pkg::PH_OPENING: begin
				if (is_tick && tick_done(reg_move))
					lk_phase = dlc_pkg::PH_HOLDING;
			end
			dlc_pkg::PH_HOLDING: begin
				if (is_tick && tick_done(reg_hold))
					lk_phase = dlc_pkg::PH_CLOSING;
			end
			dlc_pkg::PH_CLOSING: begin
				if (is_tick && tick_done(reg_move))
					lk_phase = dlc_pkg::PH_IDLE;
			end
			dlc_pkg::PH_LOCKOUT: begin
				if (is_tick && tick_done(reg_lockout)) begin
					lk_mistakes = '0;
					lk_phase    = dlc_pkg::PH_IDLE;
				end
			end
			default: start_entry(dlc_pkg::PH_ENROLL_CMD);
		endcase
		r.motor_drive = (lk_phase == dlc_pkg::PH_OPENING) ? dlc_pkg::MOTOR_FORWARD :
			(lk_phase == dlc_pkg::PH_CLOSING) ? dlc_pkg::MOTOR_REVERSE : dlc_pkg::MOTOR_STOP;
		r.alarm_on = lk_phase == dlc_pkg::PH_LOCKOUT;
		r.busy_res = lock_timed();
		return r;
	endfunction

	// one event beat; valid stays high into the next beat unless a gap is taken
	task automatic send_event(input logic [1:0] m, input logic [7:0] v);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(2, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= {m, v};
		do @(posedge clk); while (in_stall);
		expected_beats.push_back(predict_event(in_data));
	endtask

	task automatic send_code(input logic [39:0] code);
		for (int i = 0; i < CODE_LEN; i++)
			send_event(dlc_pkg::MODE_BYTE, code[8*(CODE_LEN-1-i) +: 8]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] lim, input logic [7:0] mv,
		input logic [7:0] hd, input logic [7:0] lo);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= dlc_pkg::REG_MISTAKE_LIMIT;
		cfg_data  <= lim;
		@(posedge clk);
		cfg_index <= dlc_pkg::REG_MOVE_TICKS;
		cfg_data  <= mv;
		@(posedge clk);
		cfg_index <= dlc_pkg::REG_HOLD_TICKS;
		cfg_data  <= hd;
		@(posedge clk);
		cfg_index <= dlc_pkg::REG_LOCKOUT_TICKS;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_we      <= 1'b0;
		reg_limit   = lim;
		reg_move    = mv;
		reg_hold    = hd;
		reg_lockout = lo;
		@(posedge clk);
	endtask

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (expected_beats.size() == 0) begin
				$error("result beat with nothing expected: %p", out_data);
				n_err++;
			end else begin
				exp_beat = expected_beats.pop_front();
				if (out_data.reply !== exp_beat.reply) begin
					$error("reply: expected %0d, got %0d", exp_beat.reply, out_data.reply);
					n_err++;
				end
				if (out_data.motor_drive !== exp_beat.motor_drive) begin
					$error("motor_drive: expected %0d, got %0d",
						exp_beat.motor_drive, out_data.motor_drive);
					n_err++;
				end
				if (out_data.alarm_on !== exp_beat.alarm_on) begin
					$error("alarm_on: expected %0d, got %0d",
						exp_beat.alarm_on, out_data.alarm_on);
					n_err++;
				end
				if (out_data.busy_res !== exp_beat.busy_res) begin
					$error("busy_res: expected %0d, got %0d",
						exp_beat.busy_res, out_data.busy_res);
					n_err++;
				end
			end
		end
	end

	// stray events first, a differing confirm, then the extreme code stored
	task automatic test_enrollment();
		send_event(dlc_pkg::MODE_BYTE, 8'h5A);
		send_event(dlc_pkg::MODE_TICK, 8'h00);
		send_event(MODE_UNUSED, 8'hFF);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CONFIRM);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_FIRST);
		send_code(CODE_EXTREME);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CONFIRM);
		send_code(CODE_WRONG);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_FIRST);
		send_code(CODE_EXTREME);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CONFIRM);
		send_code(CODE_EXTREME);
	endtask

	task automatic test_option_other();
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CHECK);
		send_code(CODE_WRONG);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CONFIRM);
	endtask

	task automatic test_lockout();
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CHECK);
		send_code(CODE_WRONG);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_OPEN);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CHECK);	// ignored while the buzzer sounds
		send_event(dlc_pkg::MODE_TICK, 8'hFF);
	endtask

	task automatic test_open_cycle();
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CHECK);
		send_code(CODE_EXTREME);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_OPEN);
		send_event(dlc_pkg::MODE_BYTE, 8'h00);
		repeat (3) send_event(dlc_pkg::MODE_TICK, 8'h00);
	endtask

	task automatic test_change();
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CHECK);
		send_code(CODE_EXTREME);
		send_event(dlc_pkg::MODE_CMD, dlc_pkg::CMD_CHANGE);
	endtask

	// mostly well-formed traffic steered by the predicted phase, with noise mixed in
	task automatic test_random_traffic(input logic [7:0] lim, input logic [7:0] mv,
		input logic [7:0] hd, input logic [7:0] lo, input int budget, input int pct);
		int         done;
		int         pick;
		bit         noise;
		logic [1:0] m;
		logic [7:0] v;
		program_regs(lim, mv, hd, lo);
		idle_pct  = pct;
		stall_pct = pct;
		done = 0;
		while (done < budget) begin
			noise = $urandom_range(99) < 12;
			m = dlc_pkg::MODE_TICK;
			v = 8'($urandom);
			if (noise) begin
				m = 2'($urandom_range(3));
			end else begin
				unique case (lk_phase)
					dlc_pkg::PH_ENROLL_CMD: begin
						m = dlc_pkg::MODE_CMD;
						v = dlc_pkg::CMD_FIRST;
					end
					dlc_pkg::PH_ENROLL_BYTES: begin
						m = dlc_pkg::MODE_BYTE;
						if ($urandom_range(99) < 20)
							v = $urandom_range(1) ? 8'hFF : 8'h00;
					end
					dlc_pkg::PH_CONFIRM_CMD: begin
						m = dlc_pkg::MODE_CMD;
						v = dlc_pkg::CMD_CONFIRM;
					end
					dlc_pkg::PH_CONFIRM_BYTES: begin
						m = dlc_pkg::MODE_BYTE;
						if ($urandom_range(99) >= 6)
							v = lk_first[lk_pos];
					end
					dlc_pkg::PH_IDLE: begin
						m = dlc_pkg::MODE_CMD;
						v = dlc_pkg::CMD_CHECK;
					end
					dlc_pkg::PH_CHECK_BYTES: begin
						m = dlc_pkg::MODE_BYTE;
						v = lk_stored[lk_pos];
						if ($urandom_range(99) < 8)
							v = v ^ (8'd1 << $urandom_range(7, 0));
					end
					dlc_pkg::PH_OPTION: begin
						m = dlc_pkg::MODE_CMD;
						pick = $urandom_range(99);
						if (pick < 50)
							v = dlc_pkg::CMD_OPEN;
						else if (pick < 75)
							v = dlc_pkg::CMD_CHANGE;
					end
					default: m = dlc_pkg::MODE_TICK;
				endcase
			end
			send_event(m, v);
			if (!noise)
				done++;
		end
		// run any timed phase out so the next write finds the lock at rest
		while (lock_timed())
			send_event(dlc_pkg::MODE_TICK, 8'($urandom));
		idle_pct  = 10;
		stall_pct = 10;
	endtask

	initial begin
		lock_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_enrollment();
		program_regs(8'd1, 8'd1, 8'd1, 8'd1);
		test_option_other();
		test_lockout();
		test_open_cycle();
		test_change();

		test_random_traffic(dlc_pkg::RST_MISTAKE_LIMIT, dlc_pkg::RST_MOVE_TICKS,
			dlc_pkg::RST_HOLD_TICKS, dlc_pkg::RST_LOCKOUT_TICKS, 150, 10);
		test_random_traffic(8'd1, 8'd1, 8'd1, 8'd1, 150, 10);
		test_random_traffic(8'd2, 8'd3, 8'd1, 8'd4, 180, 0);
		test_random_traffic(8'd255, 8'd1, 8'd255, 8'd1, 60, 10);
		test_random_traffic(8'd1, 8'd100, 8'd2, 8'd255, 60, 10);

		drain_results();
		$display("covered %0d events: %0d codes stored, %0d confirms differed,",
			n_events, n_stored, n_differ);
		$display("%0d opens, %0d changes, %0d wrong codes, %0d lockouts, settings 1 to 255",
			n_open, n_change, n_wrong, n_lockout);
		if (n_err == 0 && expected_beats.size() == 0)
			$display("password_door_lock_controller_core_tb: done, clean");
		else
			$display("password_door_lock_controller_core_tb: done, errors");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d results outstanding", expected_beats.size());
		$display("password_door_lock_controller_core_tb: done, errors");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/dlc_pkg.sv
hw/rtl/dlc_code_mem.sv
hw/rtl/dlc_ctrl.sv
hw/rtl/password_door_lock_controller_core.sv
verif/password_door_lock_controller_core_tb.sv
